// ----- design/biquad_filter_with_clamp_core_macros.svh -----
// ---------------------------------------------------------------------------
// Biquad filter core assertion macros
// Shared property wrappers for the checker attached to the filter core.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_FILTER_WITH_CLAMP_CORE_MACROS_SVH
`define BIQUAD_FILTER_WITH_CLAMP_CORE_MACROS_SVH

// Clocked assertion with asynchronous active-low reset as disable
`define BQCLAMP_ASSERT(lbl, clk_e, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_e) disable iff (!rst_n) prop) else $error(msg);

// Same, on the default clock and reset names
`define BQCLAMP_ASSERT_CLK(lbl, prop, msg) \
	`BQCLAMP_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ----- design/bqclamp_pkg.sv -----
// ---------------------------------------------------------------------------
// Biquad filter package
// Default widths, command and status codes, register indexes.
// ---------------------------------------------------------------------------
package bqclamp_pkg;

	// Default widths: Q16.16 samples, Q8.24 coefficients
	localparam int DEF_SAMPLE_WIDTH = 32;
	localparam int DEF_COEFF_WIDTH  = 32;
	localparam int COEFF_INT_BITS   = 8;

	// Request commands
	localparam logic CMD_FILTER  = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	// Clamp status reported with each result
	typedef enum logic [1:0] {
		CLIP_NONE  = 2'd0,
		CLIP_UPPER = 2'd1,
		CLIP_LOWER = 2'd2
	} clip_t;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_FF_GAIN_0   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FF_GAIN_1   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FF_GAIN_2   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FB_GAIN_1   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FB_GAIN_2   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT = 3'd6;

endpackage

// ----- design/bqclamp_if.sv -----
// ---------------------------------------------------------------------------
// Biquad filter channel interfaces
// Valid/ready channels for sample requests and filter results.
// ---------------------------------------------------------------------------
interface bqclamp_in_if #(
	parameter int SAMPLE_WIDTH = bqclamp_pkg::DEF_SAMPLE_WIDTH
) ();
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic signed [SAMPLE_WIDTH-1:0] preload_out;

	modport source (output valid, command, sample_in, preload_out, input ready);
	modport sink   (input valid, command, sample_in, preload_out, output ready);
endinterface

interface bqclamp_out_if #(
	parameter int SAMPLE_WIDTH = bqclamp_pkg::DEF_SAMPLE_WIDTH
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] filtered_value;
	logic [1:0]                     clip_status;

	modport source (output valid, filtered_value, clip_status, input ready);
	modport sink   (input valid, filtered_value, clip_status, output ready);
endinterface

// ----- design/bqclamp_cfg.sv -----
// ---------------------------------------------------------------------------
// Biquad filter configuration registers
// Holds the five gains and the two output limits, written by index.
// ---------------------------------------------------------------------------
module bqclamp_cfg #(
	parameter int SAMPLE_WIDTH = bqclamp_pkg::DEF_SAMPLE_WIDTH,
	parameter int COEFF_WIDTH  = bqclamp_pkg::DEF_COEFF_WIDTH,
	parameter int CFG_WIDTH    = (SAMPLE_WIDTH > COEFF_WIDTH) ? SAMPLE_WIDTH : COEFF_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bqclamp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]                cfg_wdata,
	output logic signed [COEFF_WIDTH-1:0]       ff_gain_0,
	output logic signed [COEFF_WIDTH-1:0]       ff_gain_1,
	output logic signed [COEFF_WIDTH-1:0]       ff_gain_2,
	output logic signed [COEFF_WIDTH-1:0]       fb_gain_1,
	output logic signed [COEFF_WIDTH-1:0]       fb_gain_2,
	output logic signed [SAMPLE_WIDTH-1:0]      lower_limit,
	output logic signed [SAMPLE_WIDTH-1:0]      upper_limit
);

	localparam int COEFF_FRAC = COEFF_WIDTH - bqclamp_pkg::COEFF_INT_BITS;

	// Unity gain in the coefficient format
	localparam logic [COEFF_WIDTH-1:0] UNITY_GAIN = COEFF_WIDTH'(1) << COEFF_FRAC;
	localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

	logic [COEFF_WIDTH-1:0]  ff_gain_0_q, ff_gain_1_q, ff_gain_2_q, fb_gain_1_q, fb_gain_2_q;
	logic [SAMPLE_WIDTH-1:0] lower_limit_q, upper_limit_q;

	// Write the addressed register; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_gain_0_q   <= UNITY_GAIN;
			ff_gain_1_q   <= '0;
			ff_gain_2_q   <= '0;
			fb_gain_1_q   <= '0;
			fb_gain_2_q   <= '0;
			lower_limit_q <= MOST_NEG;
			upper_limit_q <= MOST_POS;
		end else if (cfg_we) begin
			case (cfg_index)
				bqclamp_pkg::REG_FF_GAIN_0:   ff_gain_0_q   <= cfg_wdata[COEFF_WIDTH-1:0];
				bqclamp_pkg::REG_FF_GAIN_1:   ff_gain_1_q   <= cfg_wdata[COEFF_WIDTH-1:0];
				bqclamp_pkg::REG_FF_GAIN_2:   ff_gain_2_q   <= cfg_wdata[COEFF_WIDTH-1:0];
				bqclamp_pkg::REG_FB_GAIN_1:   fb_gain_1_q   <= cfg_wdata[COEFF_WIDTH-1:0];
				bqclamp_pkg::REG_FB_GAIN_2:   fb_gain_2_q   <= cfg_wdata[COEFF_WIDTH-1:0];
				bqclamp_pkg::REG_LOWER_LIMIT: lower_limit_q <= cfg_wdata[SAMPLE_WIDTH-1:0];
				bqclamp_pkg::REG_UPPER_LIMIT: upper_limit_q <= cfg_wdata[SAMPLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign ff_gain_0   = signed'(ff_gain_0_q);
	assign ff_gain_1   = signed'(ff_gain_1_q);
	assign ff_gain_2   = signed'(ff_gain_2_q);
	assign fb_gain_1   = signed'(fb_gain_1_q);
	assign fb_gain_2   = signed'(fb_gain_2_q);
	assign lower_limit = signed'(lower_limit_q);
	assign upper_limit = signed'(upper_limit_q);

endmodule

// ----- design/bqclamp_dp.sv -----
// ---------------------------------------------------------------------------
// Biquad filter datapath
// Delay taps, five-term multiply-accumulate, rounding and output clamp.
// ---------------------------------------------------------------------------
module bqclamp_dp #(
	parameter int SAMPLE_WIDTH = bqclamp_pkg::DEF_SAMPLE_WIDTH,
	parameter int COEFF_WIDTH  = bqclamp_pkg::DEF_COEFF_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           command,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic signed [SAMPLE_WIDTH-1:0] preload_out,
	input  logic signed [COEFF_WIDTH-1:0]  ff_gain_0,
	input  logic signed [COEFF_WIDTH-1:0]  ff_gain_1,
	input  logic signed [COEFF_WIDTH-1:0]  ff_gain_2,
	input  logic signed [COEFF_WIDTH-1:0]  fb_gain_1,
	input  logic signed [COEFF_WIDTH-1:0]  fb_gain_2,
	input  logic signed [SAMPLE_WIDTH-1:0] lower_limit,
	input  logic signed [SAMPLE_WIDTH-1:0] upper_limit,
	output logic signed [SAMPLE_WIDTH-1:0] filtered_value,
	output bqclamp_pkg::clip_t             clip_status
);

	localparam int COEFF_FRAC = COEFF_WIDTH - bqclamp_pkg::COEFF_INT_BITS;
	localparam int PROD_W     = SAMPLE_WIDTH + COEFF_WIDTH;
	// Three guard bits cover the sum of five products
	localparam int ACC_W      = PROD_W + 3;
	// Half an output LSB, for round half up
	localparam logic [ACC_W-1:0] ROUND_HALF =
		(COEFF_FRAC > 0) ? (ACC_W'(1) << (COEFF_FRAC - 1)) : '0;

	logic signed [SAMPLE_WIDTH-1:0] in_tap1_q, in_tap2_q, out_tap1_q, out_tap2_q;

	logic signed [PROD_W-1:0] prod_ff0, prod_ff1, prod_ff2, prod_fb1, prod_fb2;
	logic signed [ACC_W-1:0]  acc_sum, acc_scaled, upper_ext, lower_ext;
	logic signed [SAMPLE_WIDTH-1:0] filt_y, pre_y;
	bqclamp_pkg::clip_t             filt_st, pre_st;

	// Five products in parallel
	assign prod_ff0 = ff_gain_0 * sample_in;
	assign prod_ff1 = ff_gain_1 * in_tap1_q;
	assign prod_ff2 = ff_gain_2 * in_tap2_q;
	assign prod_fb1 = fb_gain_1 * out_tap1_q;
	assign prod_fb2 = fb_gain_2 * out_tap2_q;

	// Sum, round half up, scale back to the sample format
	assign acc_sum = ACC_W'(prod_ff0) + ACC_W'(prod_ff1) + ACC_W'(prod_ff2)
	               - ACC_W'(prod_fb1) - ACC_W'(prod_fb2) + signed'(ROUND_HALF);
	assign acc_scaled = acc_sum >>> COEFF_FRAC;

	assign upper_ext = ACC_W'(upper_limit);
	assign lower_ext = ACC_W'(lower_limit);

	// Filter clamp: upper test first
	always_comb begin
		if (acc_scaled > upper_ext) begin
			filt_y  = upper_limit;
			filt_st = bqclamp_pkg::CLIP_UPPER;
		end else if (acc_scaled < lower_ext) begin
			filt_y  = lower_limit;
			filt_st = bqclamp_pkg::CLIP_LOWER;
		end else begin
			filt_y  = acc_scaled[SAMPLE_WIDTH-1:0];
			filt_st = bqclamp_pkg::CLIP_NONE;
		end
	end

	// Preload clamp: limit to upper, then raise to lower so lower wins
	always_comb begin
		pre_y  = preload_out;
		pre_st = bqclamp_pkg::CLIP_NONE;
		if (pre_y > upper_limit) begin
			pre_y  = upper_limit;
			pre_st = bqclamp_pkg::CLIP_UPPER;
		end
		if (pre_y < lower_limit) begin
			pre_y  = lower_limit;
			pre_st = bqclamp_pkg::CLIP_LOWER;
		end
	end

	assign filtered_value = (command == bqclamp_pkg::CMD_PRELOAD) ? pre_y : filt_y;
	assign clip_status    = (command == bqclamp_pkg::CMD_PRELOAD) ? pre_st : filt_st;

	// Advance the delay taps on each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tap1_q  <= '0;
			in_tap2_q  <= '0;
			out_tap1_q <= '0;
			out_tap2_q <= '0;
		end else if (step) begin
			if (command == bqclamp_pkg::CMD_PRELOAD) begin
				in_tap1_q  <= sample_in;
				in_tap2_q  <= sample_in;
				out_tap1_q <= pre_y;
				out_tap2_q <= pre_y;
			end else if (filt_st != bqclamp_pkg::CLIP_NONE) begin
				// Clipped: force every tap to the violated limit
				in_tap1_q  <= filt_y;
				in_tap2_q  <= filt_y;
				out_tap1_q <= filt_y;
				out_tap2_q <= filt_y;
			end else begin
				in_tap1_q  <= sample_in;
				in_tap2_q  <= in_tap1_q;
				out_tap1_q <= filt_y;
				out_tap2_q <= out_tap1_q;
			end
		end
	end

endmodule

// ----- design/biquad_filter_with_clamp_core.sv -----
// ---------------------------------------------------------------------------
// Biquad filter with output clamp, core
// Direct-form-I second-order IIR filter with rounding and limit clamp.
// ---------------------------------------------------------------------------
//  Channel    | Direction | Payload
//  -----------+-----------+----------------------------------------------
//  sample_ch  | request   | command, sample_in, preload_out
//  result_ch  | result    | filtered_value, clip_status
//  cfg_*      | write     | cfg_we, cfg_index, cfg_wdata
//
//  One request per cycle sustained while results are taken; the delay-tap feedback
//  is combinational through the datapath. Each request passes the input register,
//  five parallel multiplies, sum, round and clamp, then the result register.
//  Result stalls hold the result register; the input register keeps taking
//  requests until both registers are full.
//  Reset clears the taps to zero and loads the default gains and limits.
// ---------------------------------------------------------------------------
module biquad_filter_with_clamp_core #(
	parameter int SAMPLE_WIDTH = bqclamp_pkg::DEF_SAMPLE_WIDTH,
	parameter int COEFF_WIDTH  = bqclamp_pkg::DEF_COEFF_WIDTH,
	parameter int CFG_WIDTH    = (SAMPLE_WIDTH > COEFF_WIDTH) ? SAMPLE_WIDTH : COEFF_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bqclamp_in_if.sink                          sample_ch,
	bqclamp_out_if.source                       result_ch,
	input  logic                                cfg_we,
	input  logic [bqclamp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]                cfg_wdata
);

	logic signed [COEFF_WIDTH-1:0]  ff_gain_0, ff_gain_1, ff_gain_2, fb_gain_1, fb_gain_2;
	logic signed [SAMPLE_WIDTH-1:0] lower_limit, upper_limit;

	logic                           valid_s1;
	logic                           command_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1, preload_s1;
	logic                           advance_s1;

	logic signed [SAMPLE_WIDTH-1:0] dp_value;
	bqclamp_pkg::clip_t             dp_status;

	logic                           valid_s2;
	logic signed [SAMPLE_WIDTH-1:0] value_s2;
	bqclamp_pkg::clip_t             status_s2;

	bqclamp_cfg #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEFF_WIDTH  (COEFF_WIDTH),
		.CFG_WIDTH    (CFG_WIDTH)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.ff_gain_0   (ff_gain_0),
		.ff_gain_1   (ff_gain_1),
		.ff_gain_2   (ff_gain_2),
		.fb_gain_1   (fb_gain_1),
		.fb_gain_2   (fb_gain_2),
		.lower_limit (lower_limit),
		.upper_limit (upper_limit)
	);

	// Move the request on when the result register is free or being drained
	assign advance_s1      = valid_s1 && (!valid_s2 || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			command_s1 <= sample_ch.command;
			sample_s1  <= sample_ch.sample_in;
			preload_s1 <= sample_ch.preload_out;
		end
	end

	bqclamp_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEFF_WIDTH  (COEFF_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance_s1),
		.command        (command_s1),
		.sample_in      (sample_s1),
		.preload_out    (preload_s1),
		.ff_gain_0      (ff_gain_0),
		.ff_gain_1      (ff_gain_1),
		.ff_gain_2      (ff_gain_2),
		.fb_gain_1      (fb_gain_1),
		.fb_gain_2      (fb_gain_2),
		.lower_limit    (lower_limit),
		.upper_limit    (upper_limit),
		.filtered_value (dp_value),
		.clip_status    (dp_status)
	);

	// Result register: load on advance, drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			value_s2  <= dp_value;
			status_s2 <= dp_status;
		end
	end

	assign result_ch.valid          = valid_s2;
	assign result_ch.filtered_value = value_s2;
	assign result_ch.clip_status    = 2'(status_s2);

endmodule

// ----- design/bqclamp_checker.sv -----
// ---------------------------------------------------------------------------
// Biquad filter port checker
// Watches the request and result channels of the filter core.
// ---------------------------------------------------------------------------
`include "biquad_filter_with_clamp_core_macros.svh"

module bqclamp_checker #(
	parameter int SAMPLE_WIDTH = bqclamp_pkg::DEF_SAMPLE_WIDTH
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic [SAMPLE_WIDTH-1:0] res_value,
	input logic [1:0]              res_status
);

	// A stalled result stays offered
	`BQCLAMP_ASSERT_CLK(a_res_hold, (res_valid && !res_ready) |=> res_valid, "result dropped while stalled")

	// A stalled result keeps its payload
	`BQCLAMP_ASSERT_CLK(a_res_stable, (res_valid && !res_ready) |=> ($stable(res_value) && $stable(res_status)), "result changed while stalled")

	// An accepted request is followed by an offered result
	`BQCLAMP_ASSERT_CLK(a_req_to_res, (req_valid && req_ready) |-> ##2 res_valid, "accepted request produced no result")

	// A free result side never back-pressures requests
	`BQCLAMP_ASSERT_CLK(a_ready_free, (!res_valid || res_ready) |-> req_ready, "request stalled with free result side")

endmodule

bind biquad_filter_with_clamp_core bqclamp_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqclamp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (sample_ch.valid),
	.req_ready  (sample_ch.ready),
	.res_valid  (result_ch.valid),
	.res_ready  (result_ch.ready),
	.res_value  (result_ch.filtered_value),
	.res_status (result_ch.clip_status)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Biquad filter with clamp, testbench
// Sends filter and preload requests through the valid/ready channel, rebuilds
// every output in a behavioral copy of the filter, and compares each result
// with it. Covers reset gains, rounding, both clamps, inverted limits, extreme
// coefficients, random configurations and a long result stall.
// ---------------------------------------------------------------------------
module tb_top;
	import bqclamp_pkg::*;

	localparam int SW         = DEF_SAMPLE_WIDTH;
	localparam int COEFF_FRAC = DEF_COEFF_WIDTH - COEFF_INT_BITS;
	localparam int ONE_Q24    = 1 << COEFF_FRAC;
	localparam int ONE_Q16    = 1 << 16;
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam longint ROUND_HALF = 64'sd1 <<< (COEFF_FRAC - 1);

	typedef struct packed {
		logic signed [SW-1:0] value;
		clip_t                status;
	} filter_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [SW-1:0] cfg_wdata;

	bqclamp_in_if  #(.SAMPLE_WIDTH(SW)) req_if ();
	bqclamp_out_if #(.SAMPLE_WIDTH(SW)) res_if ();

	biquad_filter_with_clamp_core #(
		.SAMPLE_WIDTH(SW),
		.COEFF_WIDTH (DEF_COEFF_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(req_if.sink),
		.result_ch(res_if.source),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Filter copy: gains, limits and delay taps
	logic signed [SW-1:0] ff_g0, ff_g1, ff_g2, fb_g1, fb_g2;
	logic signed [SW-1:0] lim_lo, lim_hi;
	logic signed [SW-1:0] tap_u1, tap_u2, tap_y1, tap_y2;

	filter_result_t pending_outputs[$];
	int failures;
	int requests_sent;
	int preloads_sent;
	int upper_clips;
	int lower_clips;
	int results_checked;
	bit idling_on;
	int hold_request;

	// Clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Run one request through the filter copy and return the expected output
	function automatic filter_result_t filter_and_clamp(input logic cmd,
			input logic signed [SW-1:0] u, input logic signed [SW-1:0] y0);
		logic signed [71:0] acc;
		filter_result_t r;
		r.status = CLIP_NONE;
		if (cmd == CMD_PRELOAD) begin
			r.value = y0;
			if (r.value > lim_hi) begin
				r.value  = lim_hi;
				r.status = CLIP_UPPER;
			end
			if (r.value < lim_lo) begin
				r.value  = lim_lo;
				r.status = CLIP_LOWER;
			end
			tap_u1 = u;
			tap_u2 = u;
			tap_y1 = r.value;
			tap_y2 = r.value;
		end else begin
			acc = ff_g0 * u + ff_g1 * tap_u1 + ff_g2 * tap_u2
				- fb_g1 * tap_y1 - fb_g2 * tap_y2 + ROUND_HALF;
			acc = acc >>> COEFF_FRAC;
			if (acc > lim_hi) begin
				r.value  = lim_hi;
				r.status = CLIP_UPPER;
			end else if (acc < lim_lo) begin
				r.value  = lim_lo;
				r.status = CLIP_LOWER;
			end else begin
				r.value = acc[SW-1:0];
			end
			if (r.status != CLIP_NONE) begin
				tap_u1 = r.value;
				tap_u2 = r.value;
				tap_y1 = r.value;
				tap_y2 = r.value;
			end else begin
				tap_u2 = tap_u1;
				tap_u1 = u;
				tap_y2 = tap_y1;
				tap_y1 = r.value;
			end
		end
		if (r.status == CLIP_UPPER)
			upper_clips++;
		if (r.status == CLIP_LOWER)
			lower_clips++;
		return r;
	endfunction

	// Offer one request, hold it until accepted, then record its output
	task automatic send_request(input logic cmd, input logic signed [SW-1:0] u,
			input logic signed [SW-1:0] y0);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.command     <= cmd;
		req_if.sample_in   <= u;
		req_if.preload_out <= y0;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		pending_outputs.push_back(filter_and_clamp(cmd, u, y0));
		requests_sent++;
		if (cmd == CMD_PRELOAD)
			preloads_sent++;
	endtask

	// Drop valid and wait until every expected output has arrived
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all seven registers; call only while the filter is idle
	task automatic load_filter(input logic signed [SW-1:0] g0, g1, g2, f1, f2,
			input logic signed [SW-1:0] lo, hi);
		logic [CFG_INDEX_W-1:0] regs[7];
		logic signed [SW-1:0] vals[7];
		regs = '{REG_FF_GAIN_0, REG_FF_GAIN_1, REG_FF_GAIN_2, REG_FB_GAIN_1,
			REG_FB_GAIN_2, REG_LOWER_LIMIT, REG_UPPER_LIMIT};
		vals = '{g0, g1, g2, f1, f2, lo, hi};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		ff_g0  = g0;
		ff_g1  = g1;
		ff_g2  = g2;
		fb_g1  = f1;
		fb_g2  = f2;
		lim_lo = lo;
		lim_hi = hi;
	endtask

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
			default: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
		endcase
	endfunction

	function automatic logic signed [SW-1:0] rand_gain(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [SW-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			default: return ONE_Q24;
		endcase
	endfunction

	// One random request, mostly filter steps with a preload now and then
	task automatic send_random_request();
		logic cmd;
		cmd = ($urandom_range(0, 9) == 0) ? CMD_PRELOAD : CMD_FILTER;
		send_request(cmd, rand_sample(), rand_sample());
	endtask

	// Reset gains pass samples straight through with full-range limits
	task automatic test_reset_defaults();
		send_request(CMD_FILTER, 0, 0);
		send_request(CMD_FILTER, 1, S_MAX);
		send_request(CMD_FILTER, -1, S_MIN);
		send_request(CMD_FILTER, S_MAX, 0);
		send_request(CMD_FILTER, S_MIN, 0);
		send_request(CMD_PRELOAD, S_MAX, S_MIN);
		send_request(CMD_PRELOAD, S_MIN, S_MAX);
		wait_idle();
	endtask

	// Rounding half up, both clamps, preload clamps, inverted limits
	task automatic test_corner_cases();
		// half-gain exposes rounding toward plus infinity
		load_filter(ONE_Q24 / 2, 0, 0, 0, 0, S_MIN, S_MAX);
		send_request(CMD_FILTER, 1, 0);
		send_request(CMD_FILTER, -1, 0);
		send_request(CMD_FILTER, 3, 0);
		send_request(CMD_FILTER, -3, 0);
		wait_idle();

		// full biquad with narrow limits: clip at both ends, clamp preloads
		load_filter(ONE_Q24, ONE_Q24, ONE_Q24, ONE_Q24 / 2, -(ONE_Q24 / 4),
			-1000 * ONE_Q16, 1000 * ONE_Q16);
		send_request(CMD_PRELOAD, 5 * ONE_Q16, -7 * ONE_Q16);
		send_request(CMD_FILTER, S_MAX, 0);
		send_request(CMD_FILTER, 3 * ONE_Q16, 0);
		send_request(CMD_FILTER, S_MIN, 0);
		send_request(CMD_PRELOAD, 1, S_MAX);
		send_request(CMD_PRELOAD, -1, S_MIN);
		wait_idle();

		// inverted limits: upper test wins on filter, lower wins on preload
		load_filter(ONE_Q24, 0, 0, 0, 0, 100 * ONE_Q16, -100 * ONE_Q16);
		send_request(CMD_FILTER, 0, 0);
		send_request(CMD_PRELOAD, 0, 0);
		send_request(CMD_FILTER, -200 * ONE_Q16, 0);
		wait_idle();

		// extreme coefficient words
		load_filter(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX);
		send_request(CMD_FILTER, S_MAX, 0);
		wait_idle();
		load_filter(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX);
		send_request(CMD_FILTER, S_MIN, 0);
		wait_idle();
	endtask

	// Random configurations, each followed by a stream of random requests
	task automatic test_random_filtering(input int phases, input int per_phase);
		logic signed [SW-1:0] lo, hi, t;
		for (int p = 0; p < phases; p++) begin
			case (p % 4)
				0: begin
					load_filter(rand_gain(ONE_Q24), rand_gain(ONE_Q24), rand_gain(ONE_Q24),
						rand_gain(ONE_Q24 + ONE_Q24 / 2), rand_gain(ONE_Q24 - 1),
						S_MIN, S_MAX);
				end
				1: begin
					lo = -int'($urandom_range(1 << 16, 1 << 26));
					hi = int'($urandom_range(1 << 16, 1 << 26));
					if ($urandom_range(0, 3) == 0) begin
						t  = lo;
						lo = hi;
						hi = t;
					end
					load_filter(rand_gain(ONE_Q24), rand_gain(ONE_Q24 / 2),
						rand_gain(ONE_Q24 / 2), rand_gain(ONE_Q24), rand_gain(ONE_Q24 / 2),
						lo, hi);
				end
				2: begin
					load_filter($urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				end
				default: begin
					if ($urandom_range(0, 1) != 0)
						load_filter(pick_extreme(), pick_extreme(), pick_extreme(),
							pick_extreme(), pick_extreme(), S_MIN, S_MAX);
					else
						load_filter(pick_extreme(), pick_extreme(), pick_extreme(),
							pick_extreme(), pick_extreme(), S_MAX, S_MIN);
				end
			endcase
			repeat (per_phase) send_random_request();
			wait_idle();
		end
	endtask

	// Hold off results for a long stretch while requests keep coming
	task automatic test_result_backpressure();
		load_filter(rand_gain(ONE_Q24), rand_gain(ONE_Q24), rand_gain(ONE_Q24),
			rand_gain(ONE_Q24), rand_gain(ONE_Q24 / 2), S_MIN, S_MAX);
		hold_request = 250;
		repeat (60) send_random_request();
		wait_idle();
	endtask

	// Back-to-back requests with results always taken
	task automatic test_steady_stream();
		idling_on = 1'b0;
		load_filter(rand_gain(ONE_Q24), rand_gain(ONE_Q24 / 2), rand_gain(ONE_Q24 / 2),
			rand_gain(ONE_Q24), rand_gain(ONE_Q24 / 2),
			-int'($urandom_range(1 << 16, 1 << 24)), int'($urandom_range(1 << 16, 1 << 24)));
		repeat (150) send_random_request();
		wait_idle();
	endtask

	// Result receiver: random stall bursts, plus a long hold when requested
	initial begin
		int stall_left;
		stall_left   = 0;
		res_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else if (hold_request > 0) begin
				stall_left   = hold_request - 1;
				hold_request = 0;
				res_if.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				stall_left   = $urandom_range(0, 4);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Compare every accepted result with the oldest expected output
	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected result: filtered_value %0d, clip_status %0d",
					res_if.filtered_value, res_if.clip_status);
				failures++;
			end else begin
				want = pending_outputs.pop_front();
				results_checked++;
				if (res_if.filtered_value !== want.value) begin
					$error("filtered_value: expected %0d, actual %0d",
						want.value, res_if.filtered_value);
					failures++;
				end
				if (res_if.clip_status !== want.status) begin
					$error("clip_status: expected %0d, actual %0d",
						want.status, res_if.clip_status);
					failures++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Main sequence
	initial begin
		failures        = 0;
		requests_sent   = 0;
		preloads_sent   = 0;
		upper_clips     = 0;
		lower_clips     = 0;
		results_checked = 0;
		hold_request    = 0;
		idling_on       = 1'b1;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		req_if.valid       = 1'b0;
		req_if.command     = CMD_FILTER;
		req_if.sample_in   = '0;
		req_if.preload_out = '0;
		// reset state of the filter copy
		ff_g0  = ONE_Q24;
		ff_g1  = '0;
		ff_g2  = '0;
		fb_g1  = '0;
		fb_g2  = '0;
		lim_lo = S_MIN;
		lim_hi = S_MAX;
		tap_u1 = '0;
		tap_u2 = '0;
		tap_y1 = '0;
		tap_y2 = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_corner_cases();
		test_random_filtering(8, 190);
		test_result_backpressure();
		test_steady_stream();

		$display("Checked %0d results from %0d requests (%0d preloads)",
			results_checked, requests_sent, preloads_sent);
		$display("Upper clips %0d, lower clips %0d, over reset, directed and random settings",
			upper_clips, lower_clips);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- biquad_filter_with_clamp_core.f -----
+incdir+design
design/bqclamp_pkg.sv
design/bqclamp_if.sv
design/bqclamp_cfg.sv
design/bqclamp_dp.sv
design/biquad_filter_with_clamp_core.sv
design/bqclamp_checker.sv
tb/sv/tb_top.sv
